@@ rtl/bfe_pkg.sv @@
package bfe_pkg;

    localparam int CMD_W        = 3;
    localparam int IDX_W        = 6;
    localparam int FLAG_W       = 48;
    localparam int NUM_FLAGS    = 48;
    localparam int MAX_NEST_DEF = 16;

    // Flags at or above this index read as zero.
    localparam int FLAG_LIMIT = (NUM_FLAGS < FLAG_W) ? NUM_FLAGS : FLAG_W;

    localparam logic [CMD_W-1:0] CMD_OPERAND = 3'd0;
    localparam logic [CMD_W-1:0] CMD_OPEN    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CLOSE   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_AND     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_OR      = 3'd4;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_AND  = 2'd1,
        OP_OR   = 2'd2
    } t_op;

    typedef struct packed {
        logic             value;
        logic             has_value;
        t_op              op;
    } t_level;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [IDX_W-1:0] flag_index;
        logic             last_token;
    } t_token;

    typedef struct packed {
        logic value;
        logic error;
    } t_result;

endpackage

@@ rtl/bfe_if.sv @@
interface bfe_tok_if;
    logic                          valid;
    logic                          ready;
    logic [bfe_pkg::CMD_W-1:0]     command;
    logic [bfe_pkg::IDX_W-1:0]     flag_index;
    logic                          last_token;

    modport source (output valid, output command, output flag_index, output last_token,
                    input ready);
    modport sink   (input valid, input command, input flag_index, input last_token,
                    output ready);
endinterface

interface bfe_res_if;
    logic valid;
    logic ready;
    logic value;
    logic error;

    modport source (output valid, output value, output error, input ready);
    modport sink   (input valid, input value, input error, output ready);
endinterface

interface bfe_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [bfe_pkg::FLAG_W-1:0]    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/bfe_in_reg.sv @@
module bfe_in_reg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  bfe_pkg::t_token i_tok,
    output logic            o_ready,
    output logic            o_valid,
    output bfe_pkg::t_token o_tok,
    input  logic            i_take
);
    import bfe_pkg::*;

    logic   r_valid;
    t_token r_tok;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_tok   = r_tok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_tok <= i_tok;
        end
    end

endmodule

@@ rtl/bfe_eval.sv @@
module bfe_eval #(
    parameter int MAX_NEST = bfe_pkg::MAX_NEST_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  bfe_pkg::t_token           i_tok,
    input  logic [bfe_pkg::FLAG_W-1:0] i_flags,
    input  logic                      i_res_space,
    output logic                      o_take,
    output logic                      o_res_load,
    output bfe_pkg::t_result          o_res
);
    import bfe_pkg::*;

    localparam int DW  = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;
    localparam int STK = (MAX_NEST > 1) ? MAX_NEST - 1 : 1;

    typedef struct packed {
        t_level lvl;
        logic   err;
    } t_feed;

    function automatic t_feed feed(input t_level cur, input logic v);
        t_feed f;
        f.lvl = cur;
        f.err = 1'b0;
        if (!cur.has_value) begin
            f.lvl.value     = v;
            f.lvl.has_value = 1'b1;
        end else if (cur.op == OP_AND) begin
            f.lvl.value = cur.value & v;
            f.lvl.op    = OP_NONE;
        end else if (cur.op == OP_OR) begin
            f.lvl.value = cur.value | v;
            f.lvl.op    = OP_NONE;
        end else begin
            f.err = 1'b1;
        end
        return f;
    endfunction

    t_level          r_cur;
    t_level          n_cur;
    logic [DW-1:0]   r_depth;
    logic [DW-1:0]   n_depth;
    logic            r_err;
    logic            n_err;
    t_level          r_stack [STK];
    logic            push;
    logic            pop;
    logic            flag_bit;
    logic            fin_err;
    t_feed           fed;

    assign o_take     = i_valid && (!i_tok.last_token || i_res_space);
    assign o_res_load = o_take && i_tok.last_token;

    always_comb begin
        flag_bit = 1'b0;
        if (i_tok.flag_index < IDX_W'(FLAG_LIMIT)) begin
            flag_bit = i_flags[i_tok.flag_index];
        end
    end

    always_comb begin
        n_cur   = r_cur;
        n_depth = r_depth;
        n_err   = r_err;
        push    = 1'b0;
        pop     = 1'b0;
        fed     = feed(r_stack[0], r_cur.value);
        if (!r_err) begin
            case (i_tok.command)
                CMD_OPERAND: begin
                    fed   = feed(r_cur, flag_bit);
                    n_cur = fed.lvl;
                    n_err = fed.err;
                end
                CMD_OPEN: begin
                    if (r_cur.has_value && r_cur.op == OP_NONE) begin
                        n_err = 1'b1;
                    end else if (r_depth == DW'(MAX_NEST - 1)) begin
                        n_err = 1'b1;
                    end else begin
                        push    = 1'b1;
                        n_cur   = '0;
                        n_depth = r_depth + DW'(1);
                    end
                end
                CMD_CLOSE: begin
                    if (r_depth == '0 || !r_cur.has_value || r_cur.op != OP_NONE) begin
                        n_err = 1'b1;
                    end else begin
                        pop     = 1'b1;
                        n_cur   = fed.lvl;
                        n_err   = fed.err;
                        n_depth = r_depth - DW'(1);
                    end
                end
                CMD_AND, CMD_OR: begin
                    if (!r_cur.has_value || r_cur.op != OP_NONE) begin
                        n_err = 1'b1;
                    end else begin
                        n_cur.op = (i_tok.command == CMD_AND) ? OP_AND : OP_OR;
                    end
                end
                default: begin
                    n_err = 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        fin_err     = n_err || n_depth != '0 || !n_cur.has_value || n_cur.op != OP_NONE;
        o_res.error = fin_err;
        o_res.value = !fin_err && n_cur.value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur   <= '0;
            r_depth <= '0;
            r_err   <= 1'b0;
        end else if (o_take) begin
            if (i_tok.last_token) begin
                r_cur   <= '0;
                r_depth <= '0;
                r_err   <= 1'b0;
            end else begin
                r_cur   <= n_cur;
                r_depth <= n_depth;
                r_err   <= n_err;
            end
        end
    end

    // Outer levels sit in a shift stack with the innermost at entry zero.
    always_ff @(posedge i_clk) begin
        if (o_take && push) begin
            r_stack[0] <= r_cur;
            for (int i = 1; i < STK; i++) begin
                r_stack[i] <= r_stack[i-1];
            end
        end else if (o_take && pop) begin
            for (int i = 0; i < STK - 1; i++) begin
                r_stack[i] <= r_stack[i+1];
            end
        end
    end

endmodule

@@ rtl/bfe_out_reg.sv @@
module bfe_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  bfe_pkg::t_result i_res,
    output logic             o_space,
    bfe_res_if.source        o_res
);
    import bfe_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_space     = !r_valid || o_res.ready;
    assign o_res.valid = r_valid;
    assign o_res.value = r_res.value;
    assign o_res.error = r_res.error;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_space) begin
            r_res <= i_res;
        end
    end

endmodule

@@ rtl/boolean_flag_expression_eval_core.sv @@
// Channel   Dir   Payload                              Word taken when
// i_tok     in    command, flag_index, last_token      valid && ready
// o_res     out   value, error                         valid && ready
// i_cfg     in    data (48-bit flag vector)            valid && ready
//
// A token enters the input register and is evaluated against the current level in
// the next cycle, so one token is taken every cycle unless a last token stalls; its
// result is registered in the output register and offered. Reset is synchronous and
// active low and clears the flag vector and the expression state. A result held in
// the output register stalls only a following last token; other tokens keep flowing.
module boolean_flag_expression_eval_core #(
    parameter int MAX_NEST = bfe_pkg::MAX_NEST_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bfe_tok_if.sink   i_tok,
    bfe_res_if.source o_res,
    bfe_cfg_if.sink   i_cfg
);
    import bfe_pkg::*;

    logic [FLAG_W-1:0] r_flags;
    t_token            in_tok;
    t_token            reg_tok;
    logic              reg_valid;
    logic              take;
    logic              res_space;
    logic              res_load;
    t_result           res;

    assign in_tok.command    = i_tok.command;
    assign in_tok.flag_index = i_tok.flag_index;
    assign in_tok.last_token = i_tok.last_token;
    assign i_cfg.ready       = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else if (i_cfg.valid) begin
            r_flags <= i_cfg.data;
        end
    end

    bfe_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_tok.valid),
        .i_tok   (in_tok),
        .o_ready (i_tok.ready),
        .o_valid (reg_valid),
        .o_tok   (reg_tok),
        .i_take  (take)
    );

    bfe_eval #(
        .MAX_NEST (MAX_NEST)
    ) u_eval (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (reg_valid),
        .i_tok       (reg_tok),
        .i_flags     (r_flags),
        .i_res_space (res_space),
        .o_take      (take),
        .o_res_load  (res_load),
        .o_res       (res)
    );

    bfe_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_load),
        .i_res   (res),
        .o_space (res_space),
        .o_res   (o_res)
    );

endmodule

@@ bench/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bfe_pkg::*;

    localparam int NEST = MAX_NEST_DEF;
    localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;
    localparam logic [FLAG_W-1:0] FLAGS_ALL = {FLAG_W{1'b1}};
    localparam logic [FLAG_W-1:0] FLAGS_NONE = '0;
    localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(FLAG_LIMIT - 1);
    localparam int PHASES = 6;
    localparam int PHASE_WORDS = 180;
    localparam int HOLD_OFF_CYCLES = 300;

    logic clk;
    logic rst_n;

    bfe_tok_if tok ();
    bfe_res_if res ();
    bfe_cfg_if cfg ();

    boolean_flag_expression_eval_core #(
        .MAX_NEST(NEST)
    ) DUT (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_tok  (tok),
        .o_res  (res),
        .i_cfg  (cfg)
    );

    logic [FLAG_W-1:0] flags_model;
    logic              lvl_val [NEST];
    logic              lvl_has [NEST];
    t_op               lvl_op [NEST];
    int unsigned       nest_now;
    logic              err_now;

    t_result expected_results[$];
    t_token  token_queue[$];
    t_token  draft[$];

    int  tokens_queued;
    int  tokens_taken;
    int  results_checked;
    int  cfg_writes;
    int  mismatches;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  hold_req;
    int  hold_ack;
    int  hold_left;
    logic tok_fire;
    logic cfg_fire;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic void clear_expression();
        for (int i = 0; i < NEST; i++) begin
            lvl_val[i] = 1'b0;
            lvl_has[i] = 1'b0;
            lvl_op[i]  = OP_NONE;
        end
        nest_now = 0;
        err_now  = 1'b0;
    endfunction

    function automatic void merge_operand(logic v);
        if (!lvl_has[nest_now]) begin
            lvl_val[nest_now] = v;
            lvl_has[nest_now] = 1'b1;
        end else if (lvl_op[nest_now] == OP_AND) begin
            lvl_val[nest_now] = lvl_val[nest_now] & v;
            lvl_op[nest_now]  = OP_NONE;
        end else if (lvl_op[nest_now] == OP_OR) begin
            lvl_val[nest_now] = lvl_val[nest_now] | v;
            lvl_op[nest_now]  = OP_NONE;
        end else begin
            err_now = 1'b1;
        end
    endfunction

    function automatic void eval_token(t_token t);
        logic    v;
        t_result r;
        if (!err_now) begin
            case (t.command)
                CMD_OPERAND: begin
                    merge_operand((t.flag_index < FLAG_LIMIT) ? flags_model[t.flag_index] : 1'b0);
                end
                CMD_OPEN: begin
                    if (lvl_has[nest_now] && lvl_op[nest_now] == OP_NONE) begin
                        err_now = 1'b1;
                    end else if (nest_now + 1 >= NEST) begin
                        err_now = 1'b1;
                    end else begin
                        nest_now = nest_now + 1;
                        lvl_val[nest_now] = 1'b0;
                        lvl_has[nest_now] = 1'b0;
                        lvl_op[nest_now]  = OP_NONE;
                    end
                end
                CMD_CLOSE: begin
                    if (nest_now == 0 || !lvl_has[nest_now] || lvl_op[nest_now] != OP_NONE) begin
                        err_now = 1'b1;
                    end else begin
                        v = lvl_val[nest_now];
                        lvl_val[nest_now] = 1'b0;
                        lvl_has[nest_now] = 1'b0;
                        nest_now = nest_now - 1;
                        merge_operand(v);
                    end
                end
                CMD_AND, CMD_OR: begin
                    if (!lvl_has[nest_now] || lvl_op[nest_now] != OP_NONE)
                        err_now = 1'b1;
                    else
                        lvl_op[nest_now] = (t.command == CMD_AND) ? OP_AND : OP_OR;
                end
                default: err_now = 1'b1;
            endcase
        end
        if (t.last_token) begin
            r.error = err_now || nest_now != 0 || !lvl_has[0] || lvl_op[0] != OP_NONE;
            r.value = r.error ? 1'b0 : lvl_val[0];
            expected_results.push_back(r);
            clear_expression();
        end
    endfunction

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t: %s", $time, what);
        mismatches++;
    endtask

    always @(posedge clk) begin
        t_result want;
        tok_fire <= rst_n && tok.valid && tok.ready;
        cfg_fire <= rst_n && cfg.valid && cfg.ready;
        if (rst_n) begin
            if (res.valid && res.ready) begin
                results_checked++;
                if (expected_results.size() == 0) begin
                    report_mismatch("result word arrived with nothing expected");
                end else begin
                    want = expected_results.pop_front();
                    if (res.value !== want.value)
                        report_mismatch($sformatf("value got %b want %b", res.value, want.value));
                    if (res.error !== want.error)
                        report_mismatch($sformatf("error got %b want %b", res.error, want.error));
                end
            end
            if (tok.valid && tok.ready) begin
                eval_token('{command: tok.command, flag_index: tok.flag_index,
                             last_token: tok.last_token});
                tokens_taken++;
            end
            if (cfg.valid && cfg.ready) begin
                flags_model = cfg.data;
                cfg_writes++;
            end
        end
    end

    always @(posedge clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_ack) begin
            hold_left <= HOLD_OFF_CYCLES;
            hold_ack  <= hold_req;
        end
    end

    always @(negedge clk) begin
        t_token word;
        if (!rst_n) begin
            tok.valid <= 1'b0;
        end else if (!tok.valid || tok_fire) begin
            if (token_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                word = token_queue.pop_front();
                tok.valid      <= 1'b1;
                tok.command    <= word.command;
                tok.flag_index <= word.flag_index;
                tok.last_token <= word.last_token;
            end else begin
                tok.valid <= 1'b0;
            end
        end
    end

    always @(negedge clk) begin
        if (!rst_n || hold_left != 0)
            res.ready <= 1'b0;
        else
            res.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic void add_word(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx, logic last);
        token_queue.push_back('{command: cmd, flag_index: idx, last_token: last});
        tokens_queued++;
    endfunction

    function automatic void draft_operand();
        logic [IDX_W-1:0] idx;
        if ($urandom_range(9) == 0)
            idx = IDX_W'($urandom_range(63, FLAG_LIMIT));
        else
            idx = IDX_W'($urandom_range(FLAG_LIMIT - 1));
        draft.push_back('{command: CMD_OPERAND, flag_index: idx, last_token: 1'b0});
    endfunction

    function automatic void draft_other(logic [CMD_W-1:0] cmd);
        draft.push_back('{command: cmd, flag_index: IDX_W'($urandom_range(63)), last_token: 1'b0});
    endfunction

    function automatic void draft_expr(int lim, int max_operands);
        int lvl;
        int operands;
        bit want_operand;
        lvl = 0;
        operands = 0;
        want_operand = 1'b1;
        while (1) begin
            if (want_operand) begin
                if (lvl < lim && $urandom_range(2) == 0) begin
                    draft_other(CMD_OPEN);
                    lvl++;
                end else begin
                    draft_operand();
                    operands++;
                    want_operand = 1'b0;
                end
            end else if (lvl != 0 && (operands >= max_operands || $urandom_range(2) == 0)) begin
                draft_other(CMD_CLOSE);
                lvl--;
            end else if (operands < max_operands) begin
                draft_other($urandom_range(1) ? CMD_AND : CMD_OR);
                want_operand = 1'b1;
            end else begin
                break;
            end
        end
    endfunction

    function automatic void draft_deep(int levels);
        for (int i = 0; i < levels; i++)
            draft_other(CMD_OPEN);
        draft_operand();
        for (int i = 0; i < levels; i++)
            draft_other(CMD_CLOSE);
    endfunction

    function automatic void commit_draft(bit mark_last);
        for (int i = 0; i < draft.size(); i++) begin
            if (mark_last)
                draft[i].last_token = (i == draft.size() - 1);
            add_word(draft[i].command, draft[i].flag_index, draft[i].last_token);
        end
        draft.delete();
    endfunction

    function automatic void draft_random_word(int max_cmd);
        draft.push_back('{command: CMD_W'($urandom_range(max_cmd)),
                          flag_index: IDX_W'($urandom_range(63)),
                          last_token: ($urandom_range(3) == 0)});
    endfunction

    function automatic void fill_phase(int target);
        int start;
        int kind;
        int pos;
        start = tokens_queued;
        while (tokens_queued - start < target) begin
            kind = $urandom_range(99);
            if (kind < 70) begin
                draft_expr($urandom_range(4), $urandom_range(6, 1));
                commit_draft(1'b1);
            end else if (kind < 75) begin
                draft_deep($urandom_range(NEST, NEST - 2));
                commit_draft(1'b1);
            end else if (kind < 90) begin
                draft_expr($urandom_range(3), $urandom_range(5, 1));
                pos = $urandom_range(draft.size() - 1);
                case ($urandom_range(2))
                    0: if (draft.size() > 1) draft.delete(pos);
                    1: begin
                        draft_random_word(int'(CMD_OR));
                        draft.insert(pos, draft.pop_back());
                    end
                    default: draft[pos].command = CMD_W'($urandom_range(CMD_UNUSED_HI));
                endcase
                commit_draft(1'b1);
            end else begin
                repeat ($urandom_range(4, 1)) draft_random_word(int'(CMD_UNUSED_HI));
                commit_draft(1'b0);
            end
        end
    endfunction

    task automatic write_flags(input logic [FLAG_W-1:0] v);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.data  <= v;
        do @(negedge clk); while (!cfg_fire);
        cfg.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (tokens_taken != tokens_queued || expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    initial begin
        #5_000_000;
        $display("boolean_flag_expression_eval_core: mismatch");
        $finish;
    end

    initial begin
        logic [63:0] rnd;
        rst_n          = 1'b0;
        tok.valid      = 1'b0;
        tok.command    = CMD_OPERAND;
        tok.flag_index = '0;
        tok.last_token = 1'b0;
        cfg.valid      = 1'b0;
        cfg.data       = '0;
        res.ready      = 1'b0;
        flags_model    = '0;
        tokens_queued  = 0;
        tokens_taken   = 0;
        results_checked = 0;
        cfg_writes     = 0;
        mismatches     = 0;
        hold_req       = 0;
        hold_ack       = 0;
        hold_left      = 0;
        tok_fire       = 1'b0;
        cfg_fire       = 1'b0;
        send_idle_pct  = 15;
        recv_idle_pct  = 83;
        clear_expression();

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_flags({1'b1, {(FLAG_W - 2){1'b0}}, 1'b1});
        add_word(CMD_OPERAND, 6'd0, 1'b1);
        add_word(CMD_OPERAND, IDX_TOP, 1'b1);
        add_word(CMD_OPERAND, 6'd63, 1'b1);
        add_word(CMD_OPERAND, 6'd0, 1'b0);
        add_word(CMD_AND, 6'd0, 1'b0);
        add_word(CMD_OPERAND, 6'd1, 1'b1);
        add_word(CMD_OPERAND, 6'd1, 1'b0);
        add_word(CMD_OR, 6'd63, 1'b0);
        add_word(CMD_OPERAND, IDX_TOP, 1'b1);
        add_word(CMD_OPEN, 6'd0, 1'b0);
        add_word(CMD_OPERAND, 6'd0, 1'b0);
        add_word(CMD_OR, 6'd0, 1'b0);
        add_word(CMD_OPERAND, 6'd1, 1'b0);
        add_word(CMD_CLOSE, 6'd0, 1'b0);
        add_word(CMD_AND, 6'd0, 1'b0);
        add_word(CMD_OPERAND, IDX_TOP, 1'b1);
        add_word(CMD_CLOSE, 6'd0, 1'b1);
        add_word(CMD_OPEN, 6'd0, 1'b1);
        add_word(CMD_AND, 6'd0, 1'b1);
        add_word(CMD_OPERAND, 6'd0, 1'b0);
        add_word(CMD_OPERAND, 6'd1, 1'b1);
        add_word(CMD_UNUSED_LO, 6'd0, 1'b1);
        add_word(CMD_UNUSED_HI, 6'd63, 1'b1);
        add_word(CMD_OPERAND, 6'd0, 1'b0);
        add_word(CMD_OR, 6'd0, 1'b1);
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            if (p < 2) begin
                send_idle_pct = 15;
                recv_idle_pct = 83;
            end else if (p < 4) begin
                send_idle_pct = 83;
                recv_idle_pct = 15;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            rnd = {$urandom, $urandom};
            case (p)
                1: write_flags(FLAGS_ALL);
                2: write_flags(FLAGS_NONE);
                3: write_flags({(FLAG_W / 2){2'b10}});
                5: write_flags({(FLAG_W / 2){2'b01}});
                default: write_flags(rnd[FLAG_W-1:0]);
            endcase
            // The receiver holds off while words keep coming, so the core backs up.
            if (p == 4)
                hold_req++;
            if (p == 0) begin
                draft_deep(NEST - 1);
                commit_draft(1'b1);
                draft_deep(NEST);
                commit_draft(1'b1);
            end
            fill_phase(PHASE_WORDS);
            wait_drained();
        end

        repeat (10) @(posedge clk);
        $display("Covered %0d tokens and %0d checked results over %0d flag-vector settings,",
                 tokens_taken, results_checked, cfg_writes);
        $display("with uneven idling on both sides, one long output hold-off and deep nesting.");
        if (mismatches == 0 && expected_results.size() == 0)
            $display("boolean_flag_expression_eval_core: match");
        else
            $display("boolean_flag_expression_eval_core: mismatch");
        $finish;
    end

endmodule
